// ===== rtl/core/tcosd_pkg.sv =====
// Shared types and constants for the touch coordinate orient/scale/deadband unit.
// Depends on nothing; used by the register block, controller, datapath and top level.
package tcosd_pkg;

  localparam int RAW_W     = 12;   // raw coordinate and register field width
  localparam int POS_W     = 13;   // filtered position width
  localparam int PROD_W    = 2 * RAW_W;
  localparam int DIV_BITS  = 2;    // quotient bits retired per divider cycle
  localparam int DIV_STEPS = PROD_W / DIV_BITS;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENABLED     = 3'd0;
  localparam logic [2:0] REG_DISP_WIDTH  = 3'd1;
  localparam logic [2:0] REG_DISP_HEIGHT = 3'd2;
  localparam logic [2:0] REG_ORIENTATION = 3'd3;
  localparam logic [2:0] REG_ACCURACY    = 3'd4;
  localparam logic [2:0] REG_PANEL_MAX_X = 3'd5;
  localparam logic [2:0] REG_PANEL_MAX_Y = 3'd6;

  // orientation bits
  localparam int ORI_SWAP     = 0;
  localparam int ORI_MIRROR_X = 1;
  localparam int ORI_MIRROR_Y = 2;

  localparam logic [RAW_W-1:0] RST_DISP_WIDTH  = 12'd800;
  localparam logic [RAW_W-1:0] RST_DISP_HEIGHT = 12'd480;
  localparam logic [RAW_W-1:0] RST_PANEL_MAX_X = 12'd800;
  localparam logic [RAW_W-1:0] RST_PANEL_MAX_Y = 12'd480;

  typedef struct packed {
    logic             enabled;
    logic [RAW_W-1:0] display_width;
    logic [RAW_W-1:0] display_height;
    logic [2:0]       orientation;
    logic [RAW_W-1:0] accuracy;
    logic [RAW_W-1:0] panel_max_x;
    logic [RAW_W-1:0] panel_max_y;
  } tcosd_cfg_t;

  typedef struct packed {
    logic capture;    // take the request into the datapath
    logic orient;     // swap / mirror
    logic mul;        // coordinate * display size, divider init
    logic div_step;   // two quotient bits
    logic div_store;  // saturate and keep the scaled axis
    logic axis;       // 0 = X, 1 = Y
    logic load_out;   // deadband decision, result and state update
  } tcosd_cmd_t;

  typedef struct packed {
    logic work;       // enabled and touch present: scaling needed
  } tcosd_stat_t;

endpackage

// ===== rtl/core/tcosd_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on tcosd_pkg.
module tcosd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcosd_pkg::APB_AW-1:0]    paddr,
  input  logic [tcosd_pkg::APB_DW-1:0]    pwdata,
  output logic [tcosd_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  output tcosd_pkg::tcosd_cfg_t           cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled        <= 1'b1;
      cfg.display_width  <= tcosd_pkg::RST_DISP_WIDTH;
      cfg.display_height <= tcosd_pkg::RST_DISP_HEIGHT;
      cfg.orientation    <= 3'd0;
      cfg.accuracy       <= '0;
      cfg.panel_max_x    <= tcosd_pkg::RST_PANEL_MAX_X;
      cfg.panel_max_y    <= tcosd_pkg::RST_PANEL_MAX_Y;
    end else if (wr_en) begin
      case (idx)
        tcosd_pkg::REG_ENABLED:     cfg.enabled        <= pwdata[0];
        tcosd_pkg::REG_DISP_WIDTH:  cfg.display_width  <= pwdata[tcosd_pkg::RAW_W-1:0];
        tcosd_pkg::REG_DISP_HEIGHT: cfg.display_height <= pwdata[tcosd_pkg::RAW_W-1:0];
        tcosd_pkg::REG_ORIENTATION: cfg.orientation    <= pwdata[2:0];
        tcosd_pkg::REG_ACCURACY:    cfg.accuracy       <= pwdata[tcosd_pkg::RAW_W-1:0];
        tcosd_pkg::REG_PANEL_MAX_X: cfg.panel_max_x    <= pwdata[tcosd_pkg::RAW_W-1:0];
        tcosd_pkg::REG_PANEL_MAX_Y: cfg.panel_max_y    <= pwdata[tcosd_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      tcosd_pkg::REG_ENABLED:     prdata = {{(tcosd_pkg::APB_DW-1){1'b0}}, cfg.enabled};
      tcosd_pkg::REG_DISP_WIDTH:  prdata = tcosd_pkg::APB_DW'(cfg.display_width);
      tcosd_pkg::REG_DISP_HEIGHT: prdata = tcosd_pkg::APB_DW'(cfg.display_height);
      tcosd_pkg::REG_ORIENTATION: prdata = tcosd_pkg::APB_DW'(cfg.orientation);
      tcosd_pkg::REG_ACCURACY:    prdata = tcosd_pkg::APB_DW'(cfg.accuracy);
      tcosd_pkg::REG_PANEL_MAX_X: prdata = tcosd_pkg::APB_DW'(cfg.panel_max_x);
      tcosd_pkg::REG_PANEL_MAX_Y: prdata = tcosd_pkg::APB_DW'(cfg.panel_max_y);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tcosd_ctrl.sv =====
// Sequencer: steps one request through orient, multiply, divide and deadband.
// Depends on tcosd_pkg; drives tcosd_dpath through command signals.
module tcosd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  tcosd_pkg::tcosd_stat_t   stat,
  output tcosd_pkg::tcosd_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ORIENT = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  localparam int CNT_W = $clog2(tcosd_pkg::DIV_STEPS);

  logic [2:0]       state, state_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    cnt_next       = cnt;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    cmd.axis       = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ORIENT;
        end
      end
      S_ORIENT: begin
        if (stat.work) begin
          cmd.orient = 1'b1;
          axis_next  = 1'b0;
          state_next = S_MUL;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(tcosd_pkg::DIV_STEPS - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.div_store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/tcosd_dpath.sv =====
// Datapath: request registers, swap/mirror, multiplier, radix-4 divider,
// deadband filter, stored position and result register. Depends on tcosd_pkg.
module tcosd_dpath #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcosd_pkg::tcosd_cfg_t              cfg,
  input  tcosd_pkg::tcosd_cmd_t              cmd,
  output tcosd_pkg::tcosd_stat_t             stat,
  input  logic                               touch_present,
  input  logic [tcosd_pkg::RAW_W-1:0]        raw_x,
  input  logic [tcosd_pkg::RAW_W-1:0]        raw_y,
  output logic                               status,
  output logic                               detected,
  output logic [tcosd_pkg::POS_W-1:0]        pos_x,
  output logic [tcosd_pkg::POS_W-1:0]        pos_y
);

  localparam int RW = tcosd_pkg::RAW_W;
  localparam int PW = tcosd_pkg::PROD_W;
  localparam int QW = tcosd_pkg::POS_W;
  localparam int W  = (COORD_BITS > QW) ? COORD_BITS : QW;

  logic                  touch_q, en_q;
  logic [RW-1:0]         rx, ry, cx, cy;
  logic [PW-1:0]         num;
  logic [RW-1:0]         rem;
  logic [COORD_BITS-1:0] sx, sy;
  logic [COORD_BITS-1:0] last_x, last_y;
  logic                  last_valid;

  // swap / mirror
  logic [RW-1:0] ox, oy, mx, my;
  // divider step
  logic [RW-1:0] dvs;
  logic [RW:0]   t1, t2, r1, r2;
  logic          ge1, ge2;
  logic [COORD_BITS-1:0] qsat;
  // deadband
  logic [QW-1:0] fb_x, fb_y;
  logic [W-1:0]  px, py, nx, ny, dx, dy;
  logic          upd;

  assign stat.work = en_q & touch_q;

  always_comb begin
    ox = cfg.orientation[tcosd_pkg::ORI_SWAP] ? ry : rx;
    oy = cfg.orientation[tcosd_pkg::ORI_SWAP] ? rx : ry;
    mx = (ox >= cfg.panel_max_x) ? '0 : cfg.panel_max_x - ox - 1'b1;
    my = (oy >= cfg.panel_max_y) ? '0 : cfg.panel_max_y - oy - 1'b1;
  end

  // two restoring steps per cycle; a zero divisor gives all ones, hence saturation
  always_comb begin
    dvs = cmd.axis ? cfg.panel_max_y : cfg.panel_max_x;
    t1  = {rem, num[PW-1]};
    ge1 = (t1 >= {1'b0, dvs});
    r1  = ge1 ? t1 - {1'b0, dvs} : t1;
    t2  = {r1[RW-1:0], num[PW-2]};
    ge2 = (t2 >= {1'b0, dvs});
    r2  = ge2 ? t2 - {1'b0, dvs} : t2;
    qsat = (|num[PW-1:COORD_BITS]) ? '1 : num[COORD_BITS-1:0];
  end

  always_comb begin
    fb_x = QW'({1'b0, cfg.display_width} + {1'b0, cfg.accuracy} + 1'b1);
    fb_y = QW'({1'b0, cfg.display_height} + {1'b0, cfg.accuracy} + 1'b1);
    px   = last_valid ? W'(last_x) : W'(fb_x);
    py   = last_valid ? W'(last_y) : W'(fb_y);
    nx   = W'(sx);
    ny   = W'(sy);
    dx   = (nx > px) ? nx - px : px - nx;
    dy   = (ny > py) ? ny - py : py - ny;
    upd  = en_q & touch_q & ((dx > W'(cfg.accuracy)) || (dy > W'(cfg.accuracy)));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      touch_q <= touch_present;
      en_q    <= cfg.enabled;
      rx      <= raw_x;
      ry      <= raw_y;
    end
    if (cmd.orient) begin
      cx <= cfg.orientation[tcosd_pkg::ORI_MIRROR_X] ? mx : ox;
      cy <= cfg.orientation[tcosd_pkg::ORI_MIRROR_Y] ? my : oy;
    end
    if (cmd.mul) begin
      num <= cmd.axis ? PW'(cy) * PW'(cfg.display_height)
                      : PW'(cx) * PW'(cfg.display_width);
      rem <= '0;
    end else if (cmd.div_step) begin
      num <= {num[PW-3:0], ge1, ge2};
      rem <= r2[RW-1:0];
    end
    if (cmd.div_store) begin
      if (cmd.axis) sy <= qsat;
      else          sx <= qsat;
    end
    if (cmd.load_out) begin
      status   <= ~en_q;
      detected <= en_q & touch_q;
      pos_x    <= !en_q ? '0 : (upd ? nx[QW-1:0] : px[QW-1:0]);
      pos_y    <= !en_q ? '0 : (upd ? ny[QW-1:0] : py[QW-1:0]);
      if (upd) begin
        last_x <= sx;
        last_y <= sy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (cmd.load_out && upd) begin
      last_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/touch_coordinate_orient_scale_deadband_unit.sv =====
// Top level of the touch coordinate orient/scale/deadband unit.
// Depends on tcosd_pkg, tcosd_regs, tcosd_ctrl and tcosd_dpath.
//
// Use:
//  - Input channel (in_valid/in_ready) carries one touch sample request:
//    touch_present, raw_x, raw_y. Output channel (out_valid/out_ready)
//    carries status, detected, pos_x, pos_y, one result per request.
//  - One request at a time. A touching request with the block enabled runs
//    from acceptance to out_valid through orient, then per axis multiply,
//    the divider steps and saturate, then the deadband step; the radix-4
//    divider is shared by both axes. No touch, or disabled: orient goes
//    straight to the deadband step. in_ready is high again the cycle after
//    the result is loaded, so the next request overlaps a result that is
//    still waiting; a new request is not taken before the last is loaded.
//  - If the receiver stalls, the result stays in the output register and the
//    next request is worked up to its deadband step, where it waits.
//  - APB-style configuration port, register i at byte 4*i; pready always
//    high. Write registers only while no request is in flight.
//  - Reset (rst, synchronous): registers to defaults, no stored position;
//    a first touch outside the deadband moves the position; channels empty.
module touch_coordinate_orient_scale_deadband_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               touch_present,
  input  logic [tcosd_pkg::RAW_W-1:0]        raw_x,
  input  logic [tcosd_pkg::RAW_W-1:0]        raw_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               status,
  output logic                               detected,
  output logic [tcosd_pkg::POS_W-1:0]        pos_x,
  output logic [tcosd_pkg::POS_W-1:0]        pos_y,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcosd_pkg::APB_AW-1:0]       paddr,
  input  logic [tcosd_pkg::APB_DW-1:0]       pwdata,
  output logic [tcosd_pkg::APB_DW-1:0]       prdata,
  output logic                               pready
);

  tcosd_pkg::tcosd_cfg_t  cfg;
  tcosd_pkg::tcosd_cmd_t  cmd;
  tcosd_pkg::tcosd_stat_t stat;

  tcosd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcosd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcosd_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .touch_present (touch_present),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .status        (status),
    .detected      (detected),
    .pos_x         (pos_x),
    .pos_y         (pos_y)
  );

  // one request at a time: acceptance closes the input until the result loads
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // a fresh result always hands the input side back
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded but input not reopened");

  // busy results carry no position
  a_busy_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (!detected && pos_x == '0 && pos_y == '0))
    else $error("busy result with non-zero fields");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for touch_coordinate_orient_scale_deadband_unit.
// Holds its own orient/scale/deadband predictor; needs tcosd_pkg and the unit's RTL.
// Clocked driver and monitor blocks; the stimulus block fills the request queue.
module tb_top;

  localparam int RAW_W  = tcosd_pkg::RAW_W;
  localparam int POS_W  = tcosd_pkg::POS_W;
  localparam int APB_AW = tcosd_pkg::APB_AW;
  localparam int APB_DW = tcosd_pkg::APB_DW;

  localparam int COORD_BITS   = 12;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;  // scaled value ceiling
  localparam int RAW_MAX      = (1 << RAW_W) - 1;
  localparam int POS_MASK     = (1 << POS_W) - 1;
  localparam int IDLE_PCT     = 20;       // chance of a gap on either side
  localparam int PHASE_ITEMS  = 84;       // random requests per register setting
  localparam int RANDOM_PHASES = 12;
  localparam int TAIL_CYCLES  = 40;       // a bit over one touching request
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 40;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  localparam logic [2:0] ORIENT_NONE        = 3'b000;
  localparam logic [2:0] ORIENT_SWAP        = 3'(1 << tcosd_pkg::ORI_SWAP);
  localparam logic [2:0] ORIENT_MIRROR_BOTH =
    3'((1 << tcosd_pkg::ORI_MIRROR_X) | (1 << tcosd_pkg::ORI_MIRROR_Y));
  localparam logic [2:0] ORIENT_ALL         = ORIENT_SWAP | ORIENT_MIRROR_BOTH;

  typedef struct packed {
    logic             touch;
    logic [RAW_W-1:0] x;
    logic [RAW_W-1:0] y;
  } touch_sample_t;

  typedef struct packed {
    logic             status;
    logic             detected;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } touch_result_t;

  // every block input has a known value from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              touch_present = 1'b0;
  logic [RAW_W-1:0]  raw_x = '0;
  logic [RAW_W-1:0]  raw_y = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic              detected;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor copy of the registers and the stored position
  tcosd_pkg::tcosd_cfg_t cfg_model;
  logic [POS_W-1:0]  stored_x;
  logic [POS_W-1:0]  stored_y;
  bit                have_stored;

  touch_sample_t     queued_samples[$];  // requests not yet offered
  touch_result_t     due_results[$];     // predicted answers, oldest first
  touch_sample_t     next_req;
  touch_sample_t     seen_req;
  touch_result_t     want_result;

  bit                req_taken = 1'b0;   // request accepted at the last rising edge
  bit                no_idle = 1'b0;
  int                walk_x = 0;
  int                walk_y = 0;
  int                cycle_count = 0;
  int                n_errors = 0;
  int                n_accepted = 0;
  int                n_touching = 0;
  int                n_busy = 0;
  int                n_moves = 0;
  int                n_settings = 0;

  touch_coordinate_orient_scale_deadband_unit #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .touch_present(touch_present),
    .raw_x(raw_x),
    .raw_y(raw_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .detected(detected),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor: orientation, scaling to the display, then the deadband.
  // -------------------------------------------------------------------------

  // mirror against the panel maximum; goes to 0 rather than below it
  function automatic int mirror_coord(int c, int pmax);
    if (c + 1 > pmax) return 0;
    return pmax - c - 1;
  endfunction

  // c * size / pmax, clipped at the coordinate ceiling; a zero panel maximum
  // behaves as a division giving all ones
  function automatic int scale_coord(int c, int size, int pmax);
    int q;
    if (pmax == 0) return COORD_MAX;
    q = (c * size) / pmax;
    return (q > COORD_MAX) ? COORD_MAX : q;
  endfunction

  function automatic int coord_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic touch_result_t filter_touch(touch_sample_t s);
    touch_result_t r;
    int ref_x, ref_y, cx, cy, swap_tmp, acc;
    acc = int'(cfg_model.accuracy);
    if (!cfg_model.enabled) begin
      // busy answer, stored position left alone
      r.status   = STATUS_BUSY;
      r.detected = 1'b0;
      r.pos_x    = '0;
      r.pos_y    = '0;
      n_busy++;
      return r;
    end
    if (have_stored) begin
      ref_x = int'(stored_x);
      ref_y = int'(stored_y);
    end else begin
      // nothing stored yet: a point beyond the display that any near touch
      // clears, taken from the registers as they stand now
      ref_x = (int'(cfg_model.display_width) + acc + 1) & POS_MASK;
      ref_y = (int'(cfg_model.display_height) + acc + 1) & POS_MASK;
    end
    if (s.touch) begin
      cx = int'(s.x);
      cy = int'(s.y);
      if (cfg_model.orientation[tcosd_pkg::ORI_SWAP]) begin
        swap_tmp = cx;
        cx = cy;
        cy = swap_tmp;
      end
      if (cfg_model.orientation[tcosd_pkg::ORI_MIRROR_X])
        cx = mirror_coord(cx, int'(cfg_model.panel_max_x));
      if (cfg_model.orientation[tcosd_pkg::ORI_MIRROR_Y])
        cy = mirror_coord(cy, int'(cfg_model.panel_max_y));
      cx = scale_coord(cx, int'(cfg_model.display_width), int'(cfg_model.panel_max_x));
      cy = scale_coord(cy, int'(cfg_model.display_height), int'(cfg_model.panel_max_y));
      if (coord_gap(cx, ref_x) > acc || coord_gap(cy, ref_y) > acc) begin
        stored_x    = POS_W'(cx);
        stored_y    = POS_W'(cy);
        have_stored = 1'b1;
        ref_x       = cx;
        ref_y       = cy;
        n_moves++;
      end
    end
    r.status   = STATUS_OK;
    r.detected = s.touch;
    r.pos_x    = POS_W'(ref_x);
    r.pos_y    = POS_W'(ref_y);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers queued requests at the falling edge and keeps valid and
  // payload steady until the request is taken. Gaps about one cycle in five, none while no_idle is set.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // still waiting for in_ready: hold everything
    end else if (queued_samples.size() != 0 &&
                 (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
      next_req = queued_samples.pop_front();
      in_valid      <= 1'b1;
      touch_present <= next_req.touch;
      raw_x         <= next_req.x;
      raw_y         <= next_req.y;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver back-pressure, same rate of stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string field, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // -------------------------------------------------------------------------
  // Monitor: predicts on every accepted request and checks every accepted
  // result against the oldest prediction, both at the rising edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_req.touch = touch_present;
        seen_req.x     = raw_x;
        seen_req.y     = raw_y;
        if (touch_present) n_touching++;
        n_accepted++;
        due_results.push_back(filter_touch(seen_req));
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result with nothing expected: status %0b detected %0b pos %0d,%0d",
                     $time, status, detected, pos_x, pos_y);
        end else begin
          want_result = due_results.pop_front();
          check_field("status", POS_W'(want_result.status), POS_W'(status));
          check_field("detected", POS_W'(want_result.detected), POS_W'(detected));
          check_field("pos_x", want_result.pos_x, pos_x);
          check_field("pos_y", want_result.pos_y, pos_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers. All of these are entered and left at a falling edge.
  // -------------------------------------------------------------------------

  // wait until every queued request has been offered, taken and answered
  task automatic settle_requests();
    while (queued_samples.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // APB write (setup + access), then a read back of the same register
  task automatic program_reg(input logic [2:0] idx, input logic [RAW_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tcosd_pkg::REG_ENABLED:     cfg_model.enabled        = value[0];
      tcosd_pkg::REG_DISP_WIDTH:  cfg_model.display_width  = value;
      tcosd_pkg::REG_DISP_HEIGHT: cfg_model.display_height = value;
      tcosd_pkg::REG_ORIENTATION: cfg_model.orientation    = value[2:0];
      tcosd_pkg::REG_ACCURACY:    cfg_model.accuracy       = value;
      tcosd_pkg::REG_PANEL_MAX_X: cfg_model.panel_max_x    = value;
      tcosd_pkg::REG_PANEL_MAX_Y: cfg_model.panel_max_y    = value;
      default: ;
    endcase
    @(negedge clk);
    // back-to-back read: psel stays up, new setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(value)) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: read back of register %0d, expected %0d, got %0d", $time, idx,
                 value, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int en, input int w, input int h, input int ori,
                            input int acc, input int pmx, input int pmy);
    program_reg(tcosd_pkg::REG_ENABLED, RAW_W'(en & 1));
    program_reg(tcosd_pkg::REG_DISP_WIDTH, RAW_W'(w));
    program_reg(tcosd_pkg::REG_DISP_HEIGHT, RAW_W'(h));
    program_reg(tcosd_pkg::REG_ORIENTATION, RAW_W'(ori & 7));
    program_reg(tcosd_pkg::REG_ACCURACY, RAW_W'(acc));
    program_reg(tcosd_pkg::REG_PANEL_MAX_X, RAW_W'(pmx));
    program_reg(tcosd_pkg::REG_PANEL_MAX_Y, RAW_W'(pmy));
    n_settings++;
  endtask

  task automatic queue_sample(input bit touch, input int x, input int y);
    touch_sample_t s;
    s.touch = touch;
    s.x     = RAW_W'(x);
    s.y     = RAW_W'(y);
    queued_samples.push_back(s);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > RAW_MAX) ? RAW_MAX : v);
  endfunction

  // corners and the values either side of the panel maximum
  function automatic int boundary_coord(int pmax);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return RAW_MAX;
      2: return clamp_coord(pmax - 1);
      3: return pmax;
      default: return clamp_coord(pmax + 1);
    endcase
  endfunction

  // often a finger wandering a few counts at a time, so the deadband gets
  // both sides of its threshold; plus jumps, panel edges and lifted samples
  task automatic queue_random_samples(input int count);
    int pick, span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_sample(1'b0, int'($urandom), int'($urandom));
      end else begin
        if (pick < 60) begin
          span   = $urandom_range(1, 24);
          walk_x = clamp_coord(walk_x + int'($urandom_range(0, 2 * span)) - span);
          walk_y = clamp_coord(walk_y + int'($urandom_range(0, 2 * span)) - span);
        end else if (pick < 85) begin
          walk_x = $urandom_range(0, RAW_MAX);
          walk_y = $urandom_range(0, RAW_MAX);
        end else begin
          walk_x = boundary_coord(int'(cfg_model.panel_max_x));
          walk_y = boundary_coord(int'(cfg_model.panel_max_y));
        end
        queue_sample(1'b1, walk_x, walk_y);
      end
    end
  endtask

  // mostly full-range sizes, sometimes tiny ones so scaling can saturate hard
  function automatic int pick_size();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40))
                                       : int'($urandom_range(1, RAW_MAX));
  endfunction

  task automatic random_phase(input int phase);
    int acc;
    case (phase)
      0: begin
        no_idle = 1'b1;  // the run with no gaps and no stalls
        set_config(1, 800, 480, ORIENT_SWAP, 2, 480, 800);
      end
      1: set_config(1, RAW_MAX, RAW_MAX, ORIENT_ALL, RAW_MAX, RAW_MAX, RAW_MAX);
      2: set_config(1, 0, 1, ORIENT_MIRROR_BOTH, 0, 1, RAW_MAX);
      3: set_config(0, 640, 480, ORIENT_NONE, 0, 640, 480);
      default: begin
        case ($urandom_range(0, 3))
          0: acc = 0;
          1: acc = $urandom_range(1, 8);
          2: acc = $urandom_range(0, 64);
          default: acc = $urandom_range(0, RAW_MAX);
        endcase
        set_config(1, pick_size(), pick_size(), $urandom_range(0, 7), acc,
                   pick_size(), pick_size());
      end
    endcase
    queue_random_samples(PHASE_ITEMS / 2);
    // sender holds off until every answer is back, then carries on
    settle_requests();
    queue_random_samples(PHASE_ITEMS / 2);
    settle_requests();
    no_idle = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence: reset, directed corner cases, then random settings.
  // -------------------------------------------------------------------------
  initial begin
    cfg_model.enabled        = 1'b1;
    cfg_model.display_width  = tcosd_pkg::RST_DISP_WIDTH;
    cfg_model.display_height = tcosd_pkg::RST_DISP_HEIGHT;
    cfg_model.orientation    = ORIENT_NONE;
    cfg_model.accuracy       = '0;
    cfg_model.panel_max_x    = tcosd_pkg::RST_PANEL_MAX_X;
    cfg_model.panel_max_y    = tcosd_pkg::RST_PANEL_MAX_Y;
    stored_x    = '0;
    stored_y    = '0;
    have_stored = 1'b0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings, nothing stored: lifted finger reports the virtual point
    queue_sample(1'b0, 'hABC, 'h543);
    settle_requests();

    // still nothing stored, now with the widest deadband: a far touch that
    // lands within it leaves the virtual point, which is wider than 12 bits
    set_config(1, 1, 1, ORIENT_NONE, RAW_MAX, 1, 1);
    queue_sample(1'b0, 0, 0);
    queue_sample(1'b1, RAW_MAX, RAW_MAX);
    queue_sample(1'b1, 0, 0);
    queue_sample(1'b1, RAW_MAX, RAW_MAX);
    settle_requests();

    // reset values again: corners and panel limits
    set_config(1, int'(tcosd_pkg::RST_DISP_WIDTH), int'(tcosd_pkg::RST_DISP_HEIGHT),
               ORIENT_NONE, 0, int'(tcosd_pkg::RST_PANEL_MAX_X),
               int'(tcosd_pkg::RST_PANEL_MAX_Y));
    queue_sample(1'b1, 0, 0);
    queue_sample(1'b1, RAW_MAX, RAW_MAX);
    queue_sample(1'b1, 799, 479);
    queue_sample(1'b1, 800, 480);
    queue_sample(1'b0, RAW_MAX, RAW_MAX);
    queue_sample(1'b1, 1, RAW_MAX - 1);
    settle_requests();

    // swap and both mirrors; mirror goes to 0 past the panel maximum
    set_config(1, RAW_MAX, RAW_MAX, ORIENT_ALL, 3, 1000, 600);
    queue_sample(1'b1, 0, 0);
    queue_sample(1'b1, 1000, 600);
    queue_sample(1'b1, RAW_MAX, RAW_MAX);
    queue_sample(1'b1, 2, 5);
    queue_sample(1'b0, 7, 7);
    settle_requests();

    // zero panel maximum: division by zero saturates, even for a zero height
    set_config(1, RAW_MAX, 0, ORIENT_MIRROR_BOTH, 0, 0, 0);
    queue_sample(1'b1, 5, 9);
    queue_sample(1'b1, 0, 0);
    settle_requests();

    // disabled: busy answers, stored point kept for later
    set_config(0, RAW_MAX, 0, ORIENT_MIRROR_BOTH, 0, 0, 0);
    queue_sample(1'b1, 123, 456);
    queue_sample(1'b0, RAW_MAX, 0);
    settle_requests();

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    settle_requests();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d requests (%0d with touch, %0d answered busy) over %0d settings",
             n_accepted, n_touching, n_busy, n_settings);
    $display("Stored position moved %0d times; %0d cycles; %0d mismatches",
             n_moves, cycle_count, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
